FILE: hw/rtl/smf_pkg.sv
// ----------------------------------------------------------------------------
// smf_pkg
// Shared types and constants for the MIDI track event parser.
// ----------------------------------------------------------------------------
package smf_pkg;

  localparam int unsigned MaxQtyBytesDefault = 4;
  localparam int unsigned QueueDepth         = 2;

  localparam int unsigned QtyWidth   = 28;
  localparam int unsigned CntWidth   = 3;
  localparam int unsigned TickWidth  = 31;
  localparam int unsigned TempoWidth = 24;

  localparam logic [1:0] KIND_NOTE   = 2'd0;
  localparam logic [1:0] KIND_TEMPO  = 2'd1;
  localparam logic [1:0] KIND_BADLEN = 2'd2;

  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [7:0] META_TEMPO   = 8'h51;
  localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
  localparam logic [3:0] HI_NOTE_ON   = 4'h9;
  localparam logic [3:0] HI_PROGRAM   = 4'hC;
  localparam logic [3:0] HI_PRESSURE  = 4'hD;

  typedef enum logic [2:0] {
    CLS_NOTE,
    CLS_META,
    CLS_SYSEX,
    CLS_SKIP1,
    CLS_SKIP2
  } byte_cls_e;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    byte_cls_e  cls;
  } byte_entry_t;

endpackage

FILE: hw/rtl/smf_track_event_parser.sv
// ----------------------------------------------------------------------------
// smf_track_event_parser
// Parses a MIDI file track body byte by byte into note and tempo events.
// ----------------------------------------------------------------------------
// Input channel: one track byte per beat (track_byte_i, first_of_track_i),
// with in_valid_i / in_stall_o. first_of_track_i restarts ticks and parser.
// Output channel: one event per beat on out_valid_o / out_stall_i: note
// on/off with its two data bytes, a set-tempo value, or a bad tempo length
// error, each tagged with the absolute tick count (saturating at 2^31-1).
// After an error, bytes are dropped until the next first_of_track_i.
// Throughput: one byte per cycle, set by the single-step parser loop, unless
// a stalled result holds back the last byte of the next event. That byte is
// written to the queue, then its event is loaded into the result register.
// A two-entry queue separates the input tagging from the parser; in_stall_o
// rises only when it is full. While out_stall_i holds a result, bytes that
// give no event still drain; the queue fills only at the next event.
// Reset empties the queue and the result register and clears parser state.
// ----------------------------------------------------------------------------
module smf_track_event_parser import smf_pkg::*; #(
  parameter int unsigned MAX_QUANTITY_BYTES = MaxQtyBytesDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            track_byte_i,
  input  logic                  first_of_track_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            event_kind_o,
  output logic [TickWidth-1:0]  event_ticks_o,
  output logic [7:0]            status_byte_o,
  output logic [7:0]            first_data_o,
  output logic [7:0]            second_data_o,
  output logic [TempoWidth-1:0] tempo_value_o
);

  byte_entry_t push_entry;
  byte_entry_t head;
  logic        push, pop, empty, full;

  smf_front u_front (
    .track_byte_i     (track_byte_i),
    .first_of_track_i (first_of_track_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .q_full_i         (full),
    .q_push_o         (push),
    .q_entry_o        (push_entry)
  );

  smf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .empty_o      (empty),
    .full_o       (full)
  );

  smf_back #(
    .MAX_QUANTITY_BYTES (MAX_QUANTITY_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_kind_o  (event_kind_o),
    .event_ticks_o (event_ticks_o),
    .status_byte_o (status_byte_o),
    .first_data_o  (first_data_o),
    .second_data_o (second_data_o),
    .tempo_value_o (tempo_value_o)
  );

endmodule

FILE: hw/rtl/smf_front.sv
// ----------------------------------------------------------------------------
// smf_front
// Input side: takes track bytes and tags each with its status class.
// ----------------------------------------------------------------------------
module smf_front import smf_pkg::*; (
  input  logic [7:0]  track_byte_i,
  input  logic        first_of_track_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        q_full_i,
  output logic        q_push_o,
  output byte_entry_t q_entry_o
);

  byte_cls_e cls;

  always_comb begin
    if (track_byte_i == ST_META) begin
      cls = CLS_META;
    end else if (track_byte_i == ST_SYSEX || track_byte_i == ST_SYSEX_ESC) begin
      cls = CLS_SYSEX;
    end else if (track_byte_i[7:4] == HI_NOTE_OFF || track_byte_i[7:4] == HI_NOTE_ON) begin
      cls = CLS_NOTE;
    end else if (track_byte_i[7:4] == HI_PROGRAM || track_byte_i[7:4] == HI_PRESSURE) begin
      cls = CLS_SKIP1;
    end else begin
      cls = CLS_SKIP2;
    end
  end

  assign in_stall_o      = q_full_i;
  assign q_push_o        = in_valid_i & ~q_full_i;
  assign q_entry_o.data  = track_byte_i;
  assign q_entry_o.first = first_of_track_i;
  assign q_entry_o.cls   = cls;

endmodule

FILE: hw/rtl/smf_queue.sv
// ----------------------------------------------------------------------------
// smf_queue
// Small FIFO of tagged bytes between the front and the parser.
// ----------------------------------------------------------------------------
module smf_queue import smf_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  byte_entry_t push_entry_i,
  input  logic        pop_i,
  output byte_entry_t head_o,
  output logic        empty_o,
  output logic        full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  byte_entry_t            mem_q [Depth];
  logic [PtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]        count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(Depth - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

FILE: hw/rtl/smf_back.sv
// ----------------------------------------------------------------------------
// smf_back
// Track parser: delta times, tick count, event decode and result register.
// ----------------------------------------------------------------------------
module smf_back import smf_pkg::*; #(
  parameter int unsigned MAX_QUANTITY_BYTES = MaxQtyBytesDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  byte_entry_t           head_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            event_kind_o,
  output logic [TickWidth-1:0]  event_ticks_o,
  output logic [7:0]            status_byte_o,
  output logic [7:0]            first_data_o,
  output logic [7:0]            second_data_o,
  output logic [TempoWidth-1:0] tempo_value_o
);

  localparam logic [3:0] PH_DELTA     = 4'd0;
  localparam logic [3:0] PH_STATUS    = 4'd1;
  localparam logic [3:0] PH_META_TYPE = 4'd2;
  localparam logic [3:0] PH_META_LEN  = 4'd3;
  localparam logic [3:0] PH_SYSEX_LEN = 4'd4;
  localparam logic [3:0] PH_SKIP      = 4'd5;
  localparam logic [3:0] PH_NOTE_A    = 4'd6;
  localparam logic [3:0] PH_NOTE_B    = 4'd7;
  localparam logic [3:0] PH_TEMPO     = 4'd8;

  localparam logic [CntWidth-1:0] MaxCnt = CntWidth'(MAX_QUANTITY_BYTES);
  localparam logic [TickWidth-1:0] TickMax = '1;

  logic [3:0]            phase_q, phase_d, cur_phase;
  logic [QtyWidth-1:0]   acc_q, acc_d, cur_acc;
  logic [CntWidth-1:0]   cnt_q, cnt_d, cur_cnt;
  logic [TickWidth-1:0]  ticks_q, ticks_d, cur_ticks;
  logic [7:0]            hstat_q, hstat_d, cur_hstat;
  logic [7:0]            hdata_q, hdata_d, cur_hdata;
  logic [QtyWidth-1:0]   skip_q, skip_d, cur_skip;
  logic                  is_tempo_q, is_tempo_d, cur_is_tempo;
  logic [TempoWidth-1:0] tempo_q, tempo_d, cur_tempo;
  logic                  err_q, err_d, cur_err;

  logic [7:0]            b;
  logic [QtyWidth-1:0]   q_base, q_acc;
  logic [CntWidth-1:0]   q_inc;
  logic                  q_done;
  logic [TickWidth:0]    tick_sum;
  logic [TempoWidth-1:0] tempo_sh;

  logic                  emit;
  logic [1:0]            em_kind;
  logic [7:0]            em_d2;

  logic                  out_ready;
  logic                  out_valid_q;
  logic [1:0]            kind_q;
  logic [TickWidth-1:0]  oticks_q;
  logic [7:0]            ostat_q, od1_q, od2_q;
  logic [TempoWidth-1:0] otempo_q;

  assign b = head_i.data;

  always_comb begin
    cur_phase    = head_i.first ? PH_DELTA : phase_q;
    cur_acc      = head_i.first ? '0 : acc_q;
    cur_cnt      = head_i.first ? '0 : cnt_q;
    cur_ticks    = head_i.first ? '0 : ticks_q;
    cur_hstat    = head_i.first ? '0 : hstat_q;
    cur_hdata    = head_i.first ? '0 : hdata_q;
    cur_skip     = head_i.first ? '0 : skip_q;
    cur_is_tempo = head_i.first ? 1'b0 : is_tempo_q;
    cur_tempo    = head_i.first ? '0 : tempo_q;
    cur_err      = head_i.first ? 1'b0 : err_q;
  end

  // variable-length quantity step
  always_comb begin
    q_base   = (cur_cnt == '0) ? '0 : cur_acc;
    q_acc    = {q_base[QtyWidth-8:0], b[6:0]};
    q_inc    = cur_cnt + CntWidth'(1);
    q_done   = ~b[7] | (q_inc >= MaxCnt);
    tick_sum = {1'b0, cur_ticks} + (TickWidth+1)'(cur_acc);
    tempo_sh = {cur_tempo[TempoWidth-9:0], b};
  end

  always_comb begin
    phase_d    = cur_phase;
    acc_d      = cur_acc;
    cnt_d      = cur_cnt;
    ticks_d    = cur_ticks;
    hstat_d    = cur_hstat;
    hdata_d    = cur_hdata;
    skip_d     = cur_skip;
    is_tempo_d = cur_is_tempo;
    tempo_d    = cur_tempo;
    err_d      = cur_err;
    emit       = 1'b0;
    em_kind    = KIND_NOTE;
    em_d2      = b;
    if (!cur_err) begin
      case (cur_phase)
        PH_DELTA: begin
          acc_d = q_acc;
          cnt_d = q_done ? '0 : q_inc;
          if (q_done) begin
            phase_d = PH_STATUS;
          end
        end
        PH_STATUS: begin
          ticks_d = tick_sum[TickWidth] ? TickMax : tick_sum[TickWidth-1:0];
          acc_d   = '0;
          hstat_d = b;
          case (head_i.cls)
            CLS_META:  phase_d = PH_META_TYPE;
            CLS_SYSEX: phase_d = PH_SYSEX_LEN;
            CLS_NOTE:  phase_d = PH_NOTE_A;
            CLS_SKIP1: begin
              skip_d  = QtyWidth'(1);
              phase_d = PH_SKIP;
            end
            default: begin
              skip_d  = QtyWidth'(2);
              phase_d = PH_SKIP;
            end
          endcase
        end
        PH_META_TYPE: begin
          is_tempo_d = (b == META_TEMPO);
          phase_d    = PH_META_LEN;
        end
        PH_META_LEN: begin
          acc_d = q_acc;
          cnt_d = q_done ? '0 : q_inc;
          if (q_done) begin
            if (!cur_is_tempo) begin
              skip_d  = q_acc;
              phase_d = (q_acc == '0) ? PH_DELTA : PH_SKIP;
            end else if (q_acc != QtyWidth'(3)) begin
              err_d   = 1'b1;
              phase_d = PH_DELTA;
              emit    = 1'b1;
              em_kind = KIND_BADLEN;
            end else begin
              tempo_d = '0;
              phase_d = PH_TEMPO;
            end
          end
        end
        PH_SYSEX_LEN: begin
          acc_d = q_acc;
          cnt_d = q_done ? '0 : q_inc;
          if (q_done) begin
            skip_d  = q_acc;
            phase_d = (q_acc == '0) ? PH_DELTA : PH_SKIP;
          end
        end
        PH_SKIP: begin
          skip_d = cur_skip - QtyWidth'(1);
          if (cur_skip == QtyWidth'(1)) begin
            phase_d = PH_DELTA;
          end
        end
        PH_NOTE_A: begin
          hdata_d = b;
          phase_d = PH_NOTE_B;
        end
        PH_NOTE_B: begin
          phase_d = PH_DELTA;
          emit    = 1'b1;
          em_kind = KIND_NOTE;
        end
        PH_TEMPO: begin
          tempo_d = tempo_sh;
          cnt_d   = q_inc;
          if (q_inc >= CntWidth'(3)) begin
            cnt_d   = '0;
            phase_d = PH_DELTA;
            emit    = 1'b1;
            em_kind = KIND_TEMPO;
          end
        end
        default: phase_d = PH_DELTA;
      endcase
    end
  end

  assign out_ready = ~out_valid_q | ~out_stall_i;
  assign pop_o     = ~empty_i & (~emit | out_ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_DELTA;
      acc_q      <= '0;
      cnt_q      <= '0;
      ticks_q    <= '0;
      hstat_q    <= '0;
      hdata_q    <= '0;
      skip_q     <= '0;
      is_tempo_q <= 1'b0;
      tempo_q    <= '0;
      err_q      <= 1'b0;
    end else if (pop_o) begin
      phase_q    <= phase_d;
      acc_q      <= acc_d;
      cnt_q      <= cnt_d;
      ticks_q    <= ticks_d;
      hstat_q    <= hstat_d;
      hdata_q    <= hdata_d;
      skip_q     <= skip_d;
      is_tempo_q <= is_tempo_d;
      tempo_q    <= tempo_d;
      err_q      <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= pop_o & emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      kind_q   <= em_kind;
      oticks_q <= cur_ticks;
      ostat_q  <= (em_kind == KIND_NOTE) ? cur_hstat : 8'h00;
      od1_q    <= (em_kind == KIND_NOTE) ? cur_hdata : 8'h00;
      od2_q    <= (em_kind == KIND_NOTE) ? em_d2 : 8'h00;
      otempo_q <= (em_kind == KIND_TEMPO) ? tempo_sh : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = kind_q;
  assign event_ticks_o = oticks_q;
  assign status_byte_o = ostat_q;
  assign first_data_o  = od1_q;
  assign second_data_o = od2_q;
  assign tempo_value_o = otempo_q;

  a_err_parks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> phase_q == PH_DELTA)
    else $error("error hold outside delta phase");

  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_SKIP |-> skip_q != '0)
    else $error("skip phase with nothing to skip");

  a_qty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_TEMPO |-> cnt_q < MaxCnt)
    else $error("quantity byte count out of range");

  a_no_pop_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q)
    else $error("stalled result dropped");

endmodule
